// ===== design/reflow_profile_controller_top_defines.svh =====
// assertion helpers for the rtl files, included by rpc_core
`ifndef REFLOW_PROFILE_CONTROLLER_TOP_DEFINES_SVH
`define REFLOW_PROFILE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpc assertion failed");

// next-cycle implication, checked out of reset
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpc assertion failed");

`endif

// ===== design/rpc_pkg.sv =====
package rpc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int READING_W  = 12;
  localparam int TICK_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PHASE_W    = 3;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef enum logic [PHASE_W-1:0] {
    PH_HEATUP  = 3'd0,
    PH_PREHEAT = 3'd1,
    PH_RAMP    = 3'd2,
    PH_REFLOW  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREHEAT_LOW   = 3'd0,
    CFG_PREHEAT_HIGH  = 3'd1,
    CFG_REFLOW_LOW    = 3'd2,
    CFG_REFLOW_HIGH   = 3'd3,
    CFG_PREHEAT_TICKS = 3'd4,
    CFG_REFLOW_TICKS  = 3'd5
  } cfg_idx_t;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [READING_W-1:0] PREHEAT_LOW_RST   = 12'd1015;
  localparam logic [READING_W-1:0] PREHEAT_HIGH_RST  = 12'd1117;
  localparam logic [READING_W-1:0] REFLOW_LOW_RST    = 12'd1718;
  localparam logic [READING_W-1:0] REFLOW_HIGH_RST   = 12'd1817;
  localparam logic [TICK_W-1:0]    PREHEAT_TICKS_RST = 16'd2136;
  localparam logic [TICK_W-1:0]    REFLOW_TICKS_RST  = 16'd915;

  typedef struct packed {
    logic                 mode;
    logic [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic                heater_on;
    logic                fan_on;
    logic                buzzer_on;
    logic [PHASE_W-1:0]  phase;
  } out_item_t;

  typedef struct packed {
    logic [READING_W-1:0] preheat_low;
    logic [READING_W-1:0] preheat_high;
    logic [READING_W-1:0] reflow_low;
    logic [READING_W-1:0] reflow_high;
    logic [TICK_W-1:0]    preheat_ticks;
    logic [TICK_W-1:0]    reflow_ticks;
  } cfg_t;

endpackage

// ===== design/rpc_cfg.sv =====
module rpc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output rpc_pkg::cfg_t                 cfg
);
  import rpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preheat_low   <= PREHEAT_LOW_RST;
      cfg.preheat_high  <= PREHEAT_HIGH_RST;
      cfg.reflow_low    <= REFLOW_LOW_RST;
      cfg.reflow_high   <= REFLOW_HIGH_RST;
      cfg.preheat_ticks <= PREHEAT_TICKS_RST;
      cfg.reflow_ticks  <= REFLOW_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PREHEAT_LOW:   cfg.preheat_low   <= cfg_data[READING_W-1:0];
        CFG_PREHEAT_HIGH:  cfg.preheat_high  <= cfg_data[READING_W-1:0];
        CFG_REFLOW_LOW:    cfg.reflow_low    <= cfg_data[READING_W-1:0];
        CFG_REFLOW_HIGH:   cfg.reflow_high   <= cfg_data[READING_W-1:0];
        CFG_PREHEAT_TICKS: cfg.preheat_ticks <= cfg_data[TICK_W-1:0];
        CFG_REFLOW_TICKS:  cfg.reflow_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rpc_in_stage.sv =====
module rpc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpc_pkg::in_item_t in_data,
  output logic              s1_valid,
  output rpc_pkg::in_item_t s1_data,
  input  logic              s1_take
);
  import rpc_pkg::*;

  // stage is free when empty or whenever the core consumes the held request
  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

endmodule

// ===== design/rpc_core.sv =====
`include "reflow_profile_controller_top_defines.svh"

module rpc_core (
  input  logic               clk,
  input  logic               rst,
  input  rpc_pkg::cfg_t      cfg,
  input  logic               s1_valid,
  input  rpc_pkg::in_item_t  s1_data,
  output logic               s1_take,
  output logic               out_valid,
  input  logic               out_ready,
  output rpc_pkg::out_item_t out_data
);
  import rpc_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   tick_count_next;
  logic                heater;
  logic                heater_next;
  logic                fan;
  logic                fan_next;
  logic                buzzer;
  logic                buzzer_next;
  logic [READING_W-1:0] reading;

  assign s1_take = s1_valid && (!out_valid || out_ready);
  assign reading = {s1_data.sample, 2'b00};

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    heater_next     = heater;
    fan_next        = fan;
    buzzer_next     = buzzer;
    if (s1_data.mode == MODE_TICK) begin
      if ((phase == PH_PREHEAT || phase == PH_REFLOW) && tick_count != TICK_MAX) begin
        tick_count_next = tick_count + 1'b1;
      end
    end else begin
      case (phase)
        PH_HEATUP: begin
          if (reading > cfg.preheat_low) phase_next = PH_PREHEAT;
        end
        PH_PREHEAT: begin
          if (tick_count > cfg.preheat_ticks) begin
            phase_next      = PH_RAMP;
            tick_count_next = '0;
            heater_next     = 1'b1;
          end else if (reading > cfg.preheat_high) begin
            heater_next = 1'b0;
          end else if (reading < cfg.preheat_low) begin
            heater_next = 1'b1;
          end
        end
        PH_RAMP: begin
          if (reading > cfg.reflow_low) phase_next = PH_REFLOW;
        end
        PH_REFLOW: begin
          if (tick_count > cfg.reflow_ticks) begin
            phase_next      = PH_DONE;
            tick_count_next = '0;
            heater_next     = 1'b0;
            fan_next        = 1'b1;
            buzzer_next     = 1'b1;
          end else if (reading > cfg.reflow_high) begin
            heater_next = 1'b0;
          end else if (reading < cfg.reflow_low) begin
            heater_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEATUP;
      tick_count <= '0;
      heater     <= 1'b1;
      fan        <= 1'b0;
      buzzer     <= 1'b0;
    end else if (s1_take) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      heater     <= heater_next;
      fan        <= fan_next;
      buzzer     <= buzzer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_data.heater_on <= heater_next;
      out_data.fan_on    <= fan_next;
      out_data.buzzer_on <= buzzer_next;
      out_data.phase     <= phase_next;
    end
  end

  `RPC_ASSERT_NOW(a_done_drive, phase == PH_DONE, fan && buzzer && !heater)
  `RPC_ASSERT_NEXT(a_done_sticks, phase == PH_DONE, phase == PH_DONE)
  `RPC_ASSERT_NOW(a_count_idle, phase != PH_PREHEAT && phase != PH_REFLOW, tick_count == '0)
  `RPC_ASSERT_NEXT(a_ramp_step, s1_take && phase == PH_RAMP,
                   phase == PH_RAMP || phase == PH_REFLOW)
  `RPC_ASSERT_NEXT(a_tick_keeps_phase, s1_take && s1_data.mode == MODE_TICK,
                   phase == $past(phase))

endmodule

// ===== design/reflow_profile_controller_top.sv =====
// reflow oven profile sequencer: every request is either a thermocouple sample (mode 0,
// 10-bit reading scaled by four before the band compares) or a timer tick (mode 1), and
// every request yields exactly one result showing heater, fan, buzzer and phase after it
// was handled. phases run heat-up, preheat, ramp, reflow, done; preheat and reflow use
// bang-bang heater control with hysteresis and end on the first sample that sees the tick
// count above its limit. ticks count only in preheat and reflow and saturate. in done all
// requests are ignored and the outputs hold heater off, fan and buzzer on. one request is
// taken every clock unless the result channel stalls; an accepted request waits in the
// input register until the core takes it, then lands in the result register; the phase
// and tick state update between them sets the rate. the user must write band limits and
// tick limits through the cfg port only while nothing is in flight; the block does not
// enforce this. there is no read-back and no post-reset clearing pass.
module reflow_profile_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  // sample / tick channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpc_pkg::in_item_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output rpc_pkg::out_item_t             out_data,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpc_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  in_item_t s1_data;
  logic     s1_take;

  // band and tick limits
  rpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, refilled in the same cycle the core takes its request
  rpc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (s1_take)
  );

  // phase sequencer, heater hysteresis and result register
  rpc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
